// ----- rtl/calculator_seven_segment_scan_unit_assert.svh -----
// ----------------------------------------------------------------------------
// calculator seven segment scan unit assertion macros
// shared assertion forms clocked on clk_i, held off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef CALCULATOR_SEVEN_SEGMENT_SCAN_UNIT_ASSERT_SVH
`define CALCULATOR_SEVEN_SEGMENT_SCAN_UNIT_ASSERT_SVH

// same-cycle implication
`define CSSU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cssu_pkg.sv -----
// ----------------------------------------------------------------------------
// cssu_pkg
// types, codes and segment tables of the seven segment calculator scan unit
// ----------------------------------------------------------------------------
package cssu_pkg;

  localparam int unsigned BTN_ADD = 0;
  localparam int unsigned BTN_SUB = 1;
  localparam int unsigned BTN_MUL = 2;
  localparam int unsigned BTN_DIV = 3;

  localparam logic [7:0] BLANK_RESET = 8'hC0;
  localparam logic [7:0] SEG_DASH    = 8'hBF;
  localparam logic [7:0] SEG_E       = 8'h86;
  localparam logic [7:0] SEG_R       = 8'hAF;

  localparam logic [1:0] SLOT_ONES = 2'd0;
  localparam logic [1:0] SLOT_TENS = 2'd1;
  localparam logic [1:0] SLOT_HUND = 2'd2;
  localparam logic [1:0] SLOT_TOP  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_SPLIT,
    ST_SEG
  } cssu_state_e;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic div_step;
    logic split;
    logic seg_load;
  } cssu_cmd_t;

  typedef struct packed {
    logic div_start;
    logic div_last;
  } cssu_stat_t;

  function automatic logic [7:0] seg_digit(input logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'hC0;
      4'd1:    p = 8'hF9;
      4'd2:    p = 8'hA4;
      4'd3:    p = 8'hB0;
      4'd4:    p = 8'h99;
      4'd5:    p = 8'h92;
      4'd6:    p = 8'h82;
      4'd7:    p = 8'hF8;
      4'd8:    p = 8'h80;
      4'd9:    p = 8'h90;
      default: p = 8'hC0;
    endcase
    return p;
  endfunction

  // tens digit of a value below 100, by independent threshold compares
  function automatic logic [3:0] dec_tens(input logic [6:0] r);
    logic [3:0] t;
    t = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (r >= 7'(10 * k)) begin
        t = 4'(k);
      end
    end
    return t;
  endfunction

endpackage

// ----- rtl/cssu_datapath.sv -----
// ----------------------------------------------------------------------------
// cssu_datapath
// operand capture, arithmetic, 4-step restoring divider, decimal split,
// segment selection and output payload register
// ----------------------------------------------------------------------------
module cssu_datapath import cssu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cssu_cmd_t  cmd_i,
  output cssu_stat_t stat_o,
  input  logic [3:0] lhs_i,
  input  logic [3:0] rhs_i,
  input  logic [3:0] buttons_i,
  input  logic       cfg_wen_i,
  input  logic [7:0] cfg_wdata_i,
  output logic [3:0] anodes_o,
  output logic [7:0] segments_o,
  output logic [8:0] result_value_o,
  output logic       divide_error_o
);

  logic [3:0] a_q, b_q, btn_q;
  logic [8:0] held_q, held_d;
  logic       err_q, err_d;
  logic [1:0] slot_q;
  logic [7:0] blank_q;

  logic [3:0] div_rem_q, div_quo_q;
  logic [1:0] div_cnt_q;
  logic [4:0] rem_sh;
  logic       div_ge;
  logic [4:0] rem_sub;
  logic [3:0] rem_nx, quo_nx;

  logic [7:0] prod;
  logic [8:0] held_neg;
  logic [7:0] mag;
  logic [1:0] hund;
  logic [7:0] rem100;

  logic       neg_q;
  logic [7:0] mag_q;
  logic [1:0] hund_q;
  logic [6:0] r_q;

  logic [3:0] tens;
  logic [6:0] tens_x10;
  logic [6:0] ones_full;
  logic [7:0] seg;

  logic [3:0] anodes_q;
  logic [7:0] segments_q;
  logic [8:0] result_q;
  logic       error_q;

  // divider step
  assign rem_sh  = {div_rem_q, div_quo_q[3]};
  assign div_ge  = rem_sh >= {1'b0, b_q};
  assign rem_sub = rem_sh - {1'b0, b_q};
  assign rem_nx  = div_ge ? rem_sub[3:0] : rem_sh[3:0];
  assign quo_nx  = {div_quo_q[2:0], div_ge};

  assign stat_o.div_start = (btn_q[2:0] == 3'b000) && btn_q[BTN_DIV] && (b_q != 4'd0);
  assign stat_o.div_last  = div_cnt_q == 2'd3;

  assign prod = {4'b0000, a_q} * {4'b0000, b_q};

  always_comb begin
    held_d = held_q;
    err_d  = err_q;
    if (cmd_i.exec) begin
      if (btn_q[BTN_ADD]) begin
        held_d = {5'b00000, a_q} + {5'b00000, b_q};
        err_d  = 1'b0;
      end else if (btn_q[BTN_SUB]) begin
        held_d = {5'b00000, a_q} - {5'b00000, b_q};
        err_d  = 1'b0;
      end else if (btn_q[BTN_MUL]) begin
        held_d = {1'b0, prod};
        err_d  = 1'b0;
      end else if (btn_q[BTN_DIV] && (b_q == 4'd0)) begin
        held_d = 9'd0;
        err_d  = 1'b1;
      end
    end else if (cmd_i.div_step && stat_o.div_last) begin
      held_d = {5'b00000, quo_nx};
      err_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 9'd0;
      err_q   <= 1'b0;
      slot_q  <= 2'd0;
      blank_q <= BLANK_RESET;
    end else begin
      held_q <= held_d;
      err_q  <= err_d;
      if (cfg_wen_i) begin
        blank_q <= cfg_wdata_i;
      end
      if (cmd_i.seg_load) begin
        slot_q <= slot_q + 2'd1;
      end
    end
  end

  // decimal split, first half
  assign held_neg = 9'd0 - held_q;
  assign mag      = held_q[8] ? held_neg[7:0] : held_q[7:0];
  assign hund     = (mag >= 8'd200) ? 2'd2 : ((mag >= 8'd100) ? 2'd1 : 2'd0);
  assign rem100   = mag - ((hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0));

  // decimal split, second half
  assign tens      = dec_tens(r_q);
  assign tens_x10  = {tens[3:0], 3'b000} + {2'b00, tens[3:0], 1'b0};
  assign ones_full = r_q - tens_x10;

  always_comb begin
    seg = blank_q;
    if (err_q) begin
      unique case (slot_q)
        SLOT_ONES: seg = SEG_E;
        SLOT_TENS: seg = SEG_R;
        SLOT_HUND: seg = SEG_R;
        SLOT_TOP:  seg = blank_q;
        default:   seg = blank_q;
      endcase
    end else begin
      unique case (slot_q)
        SLOT_ONES: seg = seg_digit(ones_full[3:0]);
        SLOT_TENS: begin
          if (mag_q >= 8'd10) begin
            seg = seg_digit(tens);
          end else if (neg_q) begin
            seg = SEG_DASH;
          end
        end
        SLOT_HUND: begin
          if (mag_q >= 8'd100) begin
            seg = seg_digit({2'b00, hund_q});
          end else if (neg_q && (mag_q >= 8'd10)) begin
            seg = SEG_DASH;
          end
        end
        SLOT_TOP: begin
          if (neg_q && (mag_q >= 8'd100)) begin
            seg = SEG_DASH;
          end
        end
        default: seg = blank_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      a_q   <= lhs_i;
      b_q   <= rhs_i;
      btn_q <= buttons_i;
    end
    if (cmd_i.exec) begin
      div_rem_q <= 4'd0;
      div_quo_q <= a_q;
      div_cnt_q <= 2'd0;
    end else if (cmd_i.div_step) begin
      div_rem_q <= rem_nx;
      div_quo_q <= quo_nx;
      div_cnt_q <= div_cnt_q + 2'd1;
    end
    if (cmd_i.split) begin
      neg_q  <= held_q[8];
      mag_q  <= mag;
      hund_q <= hund;
      r_q    <= rem100[6:0];
    end
    if (cmd_i.seg_load) begin
      anodes_q   <= ~(4'b0001 << slot_q);
      segments_q <= seg;
      result_q   <= held_q;
      error_q    <= err_q;
    end
  end

  assign anodes_o       = anodes_q;
  assign segments_o     = segments_q;
  assign result_value_o = result_q;
  assign divide_error_o = error_q;

endmodule

// ----- rtl/cssu_ctrl.sv -----
// ----------------------------------------------------------------------------
// cssu_ctrl
// sequencer for one scan item and the output valid flag
// ----------------------------------------------------------------------------
module cssu_ctrl import cssu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  cssu_stat_t stat_i,
  output cssu_cmd_t  cmd_o
);

  cssu_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.div_start ? ST_DIV : ST_SPLIT;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        cmd_o.split = 1'b1;
        state_d     = ST_SEG;
      end
      ST_SEG: begin
        if (out_free) begin
          cmd_o.seg_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.seg_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/calculator_seven_segment_scan_unit.sv -----
// the sequencer steps through operate, the 4 steps of the bit-serial restoring
// divider when a divide runs, decimal split and segment select; segment select
// waits while the output is stalled, and a new item is accepted only after the
// previous one has left segment select
// reset clears the held result, the error flag and the scan slot, and sets the
// blank pattern to 0xC0
// ----------------------------------------------------------------------------
// calculator_seven_segment_scan_unit
// 4-bit calculator driving one seven segment position per scan item
// ----------------------------------------------------------------------------
module calculator_seven_segment_scan_unit import cssu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // lhs, rhs, buttons, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // anodes, segments, result_value, zero pad
  output logic        m_axis_tuser,  // divide_error
  input  logic        cfg_wen_i,
  input  logic [7:0]  cfg_wdata_i
);

  cssu_cmd_t  cmd;
  cssu_stat_t stat;
  logic [3:0] anodes;
  logic [7:0] segments;
  logic [8:0] result_value;

  cssu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cssu_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .lhs_i          (s_axis_tdata[3:0]),
    .rhs_i          (s_axis_tdata[7:4]),
    .buttons_i      (s_axis_tdata[11:8]),
    .cfg_wen_i      (cfg_wen_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .anodes_o       (anodes),
    .segments_o     (segments),
    .result_value_o (result_value),
    .divide_error_o (m_axis_tuser)
  );

  assign m_axis_tdata = {3'b000, result_value, segments, anodes};

endmodule

// ----- rtl/cssu_checker.sv -----
// ----------------------------------------------------------------------------
// cssu_checker
// port-level checks of the seven segment calculator scan unit
// ----------------------------------------------------------------------------
`include "calculator_seven_segment_scan_unit_assert.svh"

module cssu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  `CSSU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output item changed while stalled")
  `CSSU_ASSERT_SAME(a_one_anode, m_axis_tvalid, $onehot(~m_axis_tdata[3:0]), "not exactly one anode enabled")
  `CSSU_ASSERT_SAME(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata[20:12] == 9'd0, "divide error with nonzero result")
  `CSSU_ASSERT_NEXT(a_one_at_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while busy")

endmodule

bind calculator_seven_segment_scan_unit cssu_checker u_cssu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
